// ----- rtl/c2u_pkg.sv -----
// Shared types, constants and functions for the character cell to UTF-8 encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package c2u_pkg;

  localparam int C2U_QUEUE_DEPTH = 4;

  localparam logic [7:0] C2U_SPACE = 8'h20;
  localparam logic [7:0] C2U_DEL   = 8'h7F;

  localparam logic [20:0] C2U_CP_SPACE      = 21'h00020;
  localparam logic [20:0] C2U_CP_FULL_BLOCK = 21'h02588;
  localparam logic [20:0] C2U_CP_LEFT_HALF  = 21'h0258C;
  localparam logic [20:0] C2U_CP_RIGHT_HALF = 21'h02590;
  localparam logic [20:0] C2U_CP_SEXTANT    = 21'h1FB00;

  localparam logic [5:0] C2U_PAT_EMPTY      = 6'h00;
  localparam logic [5:0] C2U_PAT_FULL       = 6'h3F;
  localparam logic [5:0] C2U_PAT_LEFT_HALF  = 6'h15;
  localparam logic [5:0] C2U_PAT_RIGHT_HALF = 6'h2A;

  // Byte 0 is sent first.
  localparam logic [3:0][7:0] C2U_ESC_REVERSE = {8'h6D, 8'h37, 8'h5B, 8'h1B};
  localparam logic [3:0][7:0] C2U_ESC_RESET   = {8'h6D, 8'h30, 8'h5B, 8'h1B};

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      len_m1;
  } c2u_utf8_t;

  typedef struct packed {
    c2u_utf8_t glyph;
    logic      inv;
  } c2u_desc_t;

  function automatic c2u_utf8_t c2u_utf8_encode(input logic [20:0] cp);
    c2u_utf8_t r;
    r.bytes  = '0;
    r.len_m1 = 2'd0;
    if (cp < 21'h80) begin
      r.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.len_m1   = 2'd1;
    end else if (cp < 21'h10000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.len_m1   = 2'd2;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.len_m1   = 2'd3;
    end
    return r;
  endfunction

  // Returns {hit, Latin-1 code point} for the national-variant codes.
  function automatic logic [8:0] c2u_national(input logic [6:0] ch);
    logic [8:0] r;
    case (ch)
      7'h40:   r = {1'b1, 8'hC9};
      7'h5B:   r = {1'b1, 8'hC4};
      7'h5C:   r = {1'b1, 8'hD6};
      7'h5D:   r = {1'b1, 8'hC5};
      7'h5E:   r = {1'b1, 8'hDC};
      7'h60:   r = {1'b1, 8'hE9};
      7'h7B:   r = {1'b1, 8'hE4};
      7'h7C:   r = {1'b1, 8'hF6};
      7'h7D:   r = {1'b1, 8'hE5};
      7'h7E:   r = {1'b1, 8'hFC};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/c2u_front.sv -----
// Front end: holds the escape enable register, classifies each cell and
// builds its glyph descriptor. Depends on c2u_pkg.
`default_nettype none
module c2u_front
  import c2u_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic [3:0] s_tuser,
  output logic           desc_valid,
  input  wire logic      desc_ready,
  output c2u_desc_t      desc
);

  logic        escape_enable;
  logic [6:0]  ch;
  logic [5:0]  pat;
  logic [5:0]  idx;
  logic [8:0]  nat;
  logic [20:0] cp;
  logic        is_attribute, is_blanked, is_graphic, on_cursor;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_enable <= 1'b1;
    end else if (cfg_we) begin
      escape_enable <= cfg_wdata;
    end
  end

  assign is_attribute = s_tuser[0];
  assign is_blanked   = s_tuser[1];
  assign is_graphic   = s_tuser[2];
  assign on_cursor    = s_tuser[3];

  assign ch  = s_tdata[6:0];
  assign pat = {s_tdata[6], s_tdata[4:0]};
  assign nat = c2u_national(ch);

  always_comb begin
    idx = pat - 6'd1;
    if (pat > C2U_PAT_LEFT_HALF)  idx = idx - 6'd1;
    if (pat > C2U_PAT_RIGHT_HALF) idx = idx - 6'd1;
  end

  always_comb begin
    if (is_attribute || is_blanked) begin
      cp = C2U_CP_SPACE;
    end else if (is_graphic) begin
      if (pat == C2U_PAT_EMPTY)           cp = C2U_CP_SPACE;
      else if (pat == C2U_PAT_FULL)       cp = C2U_CP_FULL_BLOCK;
      else if (pat == C2U_PAT_LEFT_HALF)  cp = C2U_CP_LEFT_HALF;
      else if (pat == C2U_PAT_RIGHT_HALF) cp = C2U_CP_RIGHT_HALF;
      else                                cp = C2U_CP_SEXTANT + {15'd0, idx};
    end else if (nat[8]) begin
      cp = {13'd0, nat[7:0]};
    end else if ({1'b0, ch} >= C2U_SPACE && {1'b0, ch} < C2U_DEL) begin
      cp = {14'd0, ch};
    end else begin
      cp = C2U_CP_SPACE;
    end
  end

  assign desc.glyph = c2u_utf8_encode(cp);
  assign desc.inv   = escape_enable & (s_tdata[7] ^ on_cursor);
  assign desc_valid = s_tvalid;
  assign s_tready   = desc_ready;

endmodule
`default_nettype wire

// ----- rtl/c2u_fifo.sv -----
// Short descriptor queue between the front end and the byte sequencer.
// Depends on c2u_pkg for the descriptor type.
`default_nettype none
module c2u_fifo
  import c2u_pkg::*;
#(
  parameter int DEPTH = C2U_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  wire c2u_desc_t wr_data,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output c2u_desc_t      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  c2u_desc_t      mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_wr, do_rd;

  assign wr_ready = count != CW'(DEPTH);
  assign rd_valid = count != '0;
  assign do_wr    = wr_valid & wr_ready;
  assign do_rd    = rd_valid & rd_ready;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/c2u_back.sv -----
// Back end: walks a descriptor a byte per unstalled cycle, wraps in reverse
// escapes where marked, into a registered output stage. Depends on c2u_pkg.
`default_nettype none
module c2u_back
  import c2u_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       desc_valid,
  output logic            desc_ready,
  input  wire c2u_desc_t  desc,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);

  logic [3:0] pos, pos_next;
  logic [3:0] last_pos;
  logic [3:0] rel;
  logic [3:0] tail;
  logic [7:0] byte_sel;
  logic       slot_free;
  logic       emit;
  logic       at_last;

  assign slot_free = !m_tvalid || m_tready;
  assign emit      = desc_valid && slot_free;
  assign last_pos  = {2'd0, desc.glyph.len_m1} + (desc.inv ? 4'd8 : 4'd0);
  assign at_last   = pos == last_pos;
  assign desc_ready = emit && at_last;

  assign rel  = desc.inv ? pos - 4'd4 : pos;
  assign tail = rel - {2'd0, desc.glyph.len_m1} - 4'd1;

  always_comb begin
    if (desc.inv && pos < 4'd4) begin
      byte_sel = C2U_ESC_REVERSE[pos[1:0]];
    end else if (rel <= {2'd0, desc.glyph.len_m1}) begin
      byte_sel = desc.glyph.bytes[rel[1:0]];
    end else begin
      byte_sel = C2U_ESC_RESET[tail[1:0]];
    end
  end

  always_comb begin
    pos_next = pos;
    if (emit) begin
      pos_next = at_last ? 4'd0 : pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= 4'd0;
      m_tvalid <= 1'b0;
    end else begin
      pos <= pos_next;
      if (slot_free) begin
        m_tvalid <= desc_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= byte_sel;
      m_tlast <= at_last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/char_cell_to_utf8_encoder.sv -----
// Character cell to UTF-8 encoder, top level.
// Depends on c2u_pkg, c2u_front, c2u_fifo and c2u_back.
//
// Use:
//   s_* takes one resolved screen cell per request: s_tdata carries the
//   character byte, s_tuser the cell flags. m_* gives the UTF-8 run for
//   that cell, one byte per request, m_tlast on its final byte.
//   cfg_we/cfg_wdata write escape_enable; write it only while idle.
// Path: an accepted cell is written into the descriptor queue, then its
//   first byte is registered into the output stage.
// Throughput: the byte sequencer sends one byte per cycle unless m_tready
//   stalls it; a cell is 1 to 4 bytes, 9 to 12 when wrapped in reverse
//   escapes. The front end takes a cell every cycle while the descriptor
//   queue (QUEUE_DEPTH entries) has room.
// Reset: queue emptied, output invalid, escape_enable set to 1.
// Stall: when m_tready is low the output byte holds; the queue fills, then
//   s_tready drops until the sequencer moves again.
`default_nettype none
module char_cell_to_utf8_encoder
  import c2u_pkg::*;
#(
  parameter int QUEUE_DEPTH = C2U_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_wdata,   // escape_enable
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,     // [7:0] char_code
  // [0] is_attribute, [1] is_blanked, [2] is_graphic, [3] on_cursor
  input  wire logic [3:0] s_tuser,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,     // [7:0] out_byte
  output logic            m_tlast
);

  c2u_desc_t front_desc, back_desc;
  logic      front_valid, front_ready;
  logic      back_valid, back_ready;

  c2u_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .desc_valid (front_valid),
    .desc_ready (front_ready),
    .desc       (front_desc)
  );

  c2u_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_desc),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_desc)
  );

  c2u_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (back_valid),
    .desc_ready (back_ready),
    .desc       (back_desc),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
`default_nettype wire
